>>> src/frm_pkg.sv
`timescale 1ns / 1ps
// Package for the frame rate meter: shared types, widths and constants.
// Used by frm_serial_div and frame_rate_meter_ema.
package frm_pkg;

    localparam int DivQw   = 28;
    localparam int DivRw   = 33;
    localparam int DivCw   = 5;

    localparam logic [DivQw-1:0] RATE_NUM     = 28'd256000000;
    localparam logic [23:0]      RATE_MAX     = 24'hFFFFFF;
    localparam logic [DivCw-1:0] DIV1_STEPS   = 5'd28;
    localparam logic [DivCw-1:0] DIV2_STEPS   = 5'd24;
    localparam logic [DivCw-1:0] MUL_STEPS    = 5'd24;

    localparam logic [1:0]  CFG_REFRESH_PERIOD = 2'd0;
    localparam logic [1:0]  CFG_SMOOTHING_TIME = 2'd1;
    localparam logic [25:0] REFRESH_RESET      = 26'd500000;
    localparam logic [25:0] SMOOTHING_RESET    = 26'd1000000;

    typedef struct packed {
        logic             start;
        logic [DivCw-1:0] steps;
    } div_req_t;

endpackage

>>> src/frame_rate_meter_ema.sv
`timescale 1ns / 1ps
// Top level of the exponentially smoothed frame rate meter.
// Depends on frm_pkg and frm_serial_div.
//
// Usage: each request on the evt channel (evt_valid, evt_stall, timestamp_us)
// is a frame-end event with a microsecond timestamp. Every event yields exactly
// one request on the res channel (res_valid, res_stall) carrying rate_q8,
// measured and refresh. Registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high.
// The first event after reset and an event with zero interval go straight to
// ST_DONE. A measured event passes a bit-serial division for the instantaneous
// rate, a shift-add multiply and a bit-serial division for the blend; the two
// divisions share one divider. When the smoothed rate is zero the multiply and
// second division are skipped.
// One event is processed at a time; evt_stall is high while an event is in work.
// The next event is accepted while the previous result still waits on a stalled
// receiver; a finished result waits until the output register is free.
// Reset clears all history, the smoothed rate and the refresh accumulator, and
// restores the register defaults.
module frame_rate_meter_ema
    import frm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        evt_valid,
    output logic        evt_stall,
    input  logic [31:0] timestamp_us,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [23:0] rate_q8,
    output logic        measured,
    output logic        refresh,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [25:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV1 = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV2 = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic             have_prev_reg, have_prev_next;
    logic [31:0]      prev_time_reg, prev_time_next;
    logic [23:0]      smooth_reg, smooth_next;
    logic [31:0]      elapsed_reg, elapsed_next;
    logic [25:0]      period_reg, period_next;
    logic [25:0]      tconst_reg, tconst_next;
    logic [31:0]      dt_reg, dt_next;
    logic [55:0]      prod_reg, prod_next;
    logic             up_reg, up_next;
    logic [DivCw-1:0] cnt_reg, cnt_next;
    logic             meas_reg, meas_next;
    logic             refr_reg, refr_next;
    logic             res_valid_reg, res_valid_next;
    logic [23:0]      res_rate_reg, res_rate_next;
    logic             res_meas_reg, res_meas_next;
    logic             res_refr_reg, res_refr_next;

    div_req_t         div_req;
    logic [DivRw-1:0] div_rem_init;
    logic [DivQw-1:0] div_dvd_init;
    logic [DivRw-1:0] div_divisor;
    logic             div_busy;
    logic             div_done;
    logic [DivQw-1:0] div_quo;

    logic             evt_take;
    logic             out_free;
    logic [31:0]      dt_new;
    logic [23:0]      inst;
    logic [32:0]      mul_sum;
    logic [31:0]      addend;
    logic [32:0]      acc_sum;
    logic [31:0]      acc_sat;

    frm_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .rem_init (div_rem_init),
        .dvd_init (div_dvd_init),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign evt_stall = (state_reg != ST_IDLE);
    assign evt_take  = evt_valid && !evt_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign cfg_ready = 1'b1;

    assign dt_new  = timestamp_us - prev_time_reg;
    assign inst    = (div_quo[DivQw-1:24] != '0) ? RATE_MAX : div_quo[23:0];
    assign addend  = prod_reg[0] ? dt_reg : 32'd0;
    assign mul_sum = {1'b0, prod_reg[55:24]} + {1'b0, addend};
    assign acc_sum = {1'b0, elapsed_reg} + {1'b0, dt_reg};
    assign acc_sat = acc_sum[32] ? 32'hFFFFFFFF : acc_sum[31:0];

    always_comb
    begin
        state_next     = state_reg;
        have_prev_next = have_prev_reg;
        prev_time_next = prev_time_reg;
        smooth_next    = smooth_reg;
        elapsed_next   = elapsed_reg;
        period_next    = period_reg;
        tconst_next    = tconst_reg;
        dt_next        = dt_reg;
        prod_next      = prod_reg;
        up_next        = up_reg;
        cnt_next       = cnt_reg;
        meas_next      = meas_reg;
        refr_next      = refr_reg;
        res_valid_next = res_valid_reg;
        res_rate_next  = res_rate_reg;
        res_meas_next  = res_meas_reg;
        res_refr_next  = res_refr_reg;
        div_req.start  = 1'b0;
        div_req.steps  = DIV1_STEPS;
        div_rem_init   = '0;
        div_dvd_init   = RATE_NUM;
        div_divisor    = {1'b0, dt_reg};

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_REFRESH_PERIOD)
            begin
                period_next = cfg_data;
            end
            else if (cfg_index == CFG_SMOOTHING_TIME)
            begin
                tconst_next = cfg_data;
            end
        end

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_take)
                begin
                    meas_next      = 1'b0;
                    refr_next      = 1'b0;
                    have_prev_next = 1'b1;
                    prev_time_next = timestamp_us;
                    dt_next        = dt_new;
                    if (have_prev_reg && (dt_new != 32'd0))
                    begin
                        div_req.start = 1'b1;
                        div_divisor   = {1'b0, dt_new};
                        state_next    = ST_DIV1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    if (smooth_reg == 24'd0)
                    begin
                        smooth_next = inst;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        up_next    = (inst >= smooth_reg);
                        prod_next  = {32'd0, (inst >= smooth_reg) ? inst - smooth_reg
                                                                  : smooth_reg - inst};
                        cnt_next   = MUL_STEPS;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = {mul_sum, prod_reg[23:1]};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == DivCw'(1))
                begin
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (!div_busy && !div_done)
                begin
                    div_req.start = 1'b1;
                    div_req.steps = DIV2_STEPS;
                    div_rem_init  = {1'b0, prod_reg[55:24]};
                    div_dvd_init  = {prod_reg[23:0], 4'b0000};
                    div_divisor   = {1'b0, dt_reg} + {7'd0, tconst_reg};
                end
                else if (div_done)
                begin
                    smooth_next = up_reg ? smooth_reg + div_quo[23:0]
                                         : smooth_reg - div_quo[23:0];
                    state_next  = ST_FIN;
                end
            end
            ST_FIN:
            begin
                meas_next = 1'b1;
                if (acc_sat >= {6'd0, period_reg})
                begin
                    elapsed_next = 32'd0;
                    refr_next    = 1'b1;
                end
                else
                begin
                    elapsed_next = acc_sat;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_rate_next  = smooth_reg;
                    res_meas_next  = meas_reg;
                    res_refr_next  = refr_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            prev_time_reg <= 32'd0;
            smooth_reg    <= 24'd0;
            elapsed_reg   <= 32'd0;
            period_reg    <= REFRESH_RESET;
            tconst_reg    <= SMOOTHING_RESET;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            prev_time_reg <= prev_time_next;
            smooth_reg    <= smooth_next;
            elapsed_reg   <= elapsed_next;
            period_reg    <= period_next;
            tconst_reg    <= tconst_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg       <= dt_next;
        prod_reg     <= prod_next;
        up_reg       <= up_next;
        meas_reg     <= meas_next;
        refr_reg     <= refr_next;
        res_rate_reg <= res_rate_next;
        res_meas_reg <= res_meas_next;
        res_refr_reg <= res_refr_next;
    end

    assign res_valid = res_valid_reg;
    assign rate_q8   = res_rate_reg;
    assign measured  = res_meas_reg;
    assign refresh   = res_refr_reg;

    // A new result is loaded only from the final state of an event.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished event");

    // A refresh is only ever reported together with a measurement.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && refresh) |-> measured)
        else $error("refresh without measurement");

    // A measured result requires a stored previous timestamp.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && measured) |-> have_prev_reg)
        else $error("measurement without previous timestamp");

    // The divider is quiet whenever the block waits for an event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!div_busy && !div_done))
        else $error("divider active while idle");

endmodule

>>> src/frm_serial_div.sv
`timescale 1ns / 1ps
// Restoring divider that retires one quotient bit per cycle.
// Depends on frm_pkg for widths and the request struct.
module frm_serial_div
    import frm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    input  logic [DivRw-1:0] rem_init,
    input  logic [DivQw-1:0] dvd_init,
    input  logic [DivRw-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DivQw-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DivCw-1:0] cnt_reg, cnt_next;
    logic [DivRw-1:0] rem_reg, rem_next;
    logic [DivRw-1:0] dsr_reg, dsr_next;
    logic [DivQw-1:0] dvd_reg, dvd_next;
    logic [DivQw-1:0] quo_reg, quo_next;
    logic [DivRw:0]   shifted;
    logic [DivRw+1:0] diff;
    logic             fits;

    assign shifted = {rem_reg, dvd_reg[DivQw-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign fits    = !diff[DivRw+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = rem_init;
            dsr_next  = divisor;
            dvd_next  = dvd_init;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DivRw-1:0] : shifted[DivRw-1:0];
            dvd_next = {dvd_reg[DivQw-2:0], 1'b0};
            quo_next = {quo_reg[DivQw-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DivCw'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> verif/frame_rate_meter_ema_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_rate_meter_ema. It uses frm_pkg for the register codes.
// A cycle-free predictor of the smoothed frame rate checks every reading in the order it was
// requested, under several register settings and with random idle cycles on both channels.
module frame_rate_meter_ema_tb;
    import frm_pkg::*;

    localparam logic [1:0]  CFG_SPARE_LOW       = 2'd2;
    localparam logic [1:0]  CFG_SPARE_HIGH      = 2'd3;
    localparam logic [25:0] CFG_ALL_ONES        = 26'h3FF_FFFF;
    localparam logic [25:0] CFG_RANGE_TOP       = 26'd60000000;
    localparam logic [63:0] FPS_Q8_SCALE        = 64'd256000000;
    localparam logic [63:0] FPS_Q8_CEIL         = 64'hFF_FFFF;
    localparam int          WATCHDOG_CYCLES     = 4000;
    localparam int          SETTLE_CYCLES       = 200;

    typedef struct packed {
        logic [23:0] rate_q8;
        logic        measured;
        logic        refresh;
    } fps_reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        evt_valid = 1'b0;
    logic        evt_stall;
    logic [31:0] timestamp_us = 32'd0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [23:0] rate_q8;
    logic        measured;
    logic        refresh;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_REFRESH_PERIOD;
    logic [25:0] cfg_data = 26'd0;

    fps_reading_t expected_readings [$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    logic [31:0]  stamp_clock = 32'd0;

    logic         seen_frame = 1'b0;
    logic [31:0]  last_stamp = 32'd0;
    logic [23:0]  smoothed_fps = 24'd0;
    logic [31:0]  elapsed_us = 32'd0;
    logic [25:0]  refresh_period = 26'd500000;
    logic [25:0]  smoothing_time = 26'd1000000;

    frame_rate_meter_ema i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt_valid    (evt_valid),
        .evt_stall    (evt_stall),
        .timestamp_us (timestamp_us),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .rate_q8      (rate_q8),
        .measured     (measured),
        .refresh      (refresh),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void advance_meter(input logic [31:0] stamp);
        fps_reading_t reading;
        logic [31:0]  dt;
        logic [63:0]  inst;
        logic [63:0]  gap;
        logic [63:0]  step;
        logic [32:0]  sum;
        reading = '0;
        if (!seen_frame)
        begin
            seen_frame = 1'b1;
            last_stamp = stamp;
        end
        else
        begin
            dt = stamp - last_stamp;
            last_stamp = stamp;
            if (dt != 32'd0)
            begin
                inst = FPS_Q8_SCALE / {32'd0, dt};
                if (inst > FPS_Q8_CEIL)
                    inst = FPS_Q8_CEIL;
                if (smoothed_fps == 24'd0)
                    smoothed_fps = inst[23:0];
                else
                begin
                    if (inst[23:0] >= smoothed_fps)
                        gap = inst - {40'd0, smoothed_fps};
                    else
                        gap = {40'd0, smoothed_fps} - inst;
                    step = ({32'd0, dt} * gap) / ({32'd0, dt} + {38'd0, smoothing_time});
                    if (inst[23:0] >= smoothed_fps)
                        smoothed_fps = smoothed_fps + step[23:0];
                    else
                        smoothed_fps = smoothed_fps - step[23:0];
                end
                reading.measured = 1'b1;
                sum = {1'b0, elapsed_us} + {1'b0, dt};
                elapsed_us = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                if (elapsed_us >= {6'd0, refresh_period})
                begin
                    elapsed_us = 32'd0;
                    reading.refresh = 1'b1;
                end
            end
        end
        reading.rate_q8 = smoothed_fps;
        expected_readings.push_back(reading);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_REFRESH_PERIOD: refresh_period = cfg_data;
                    CFG_SMOOTHING_TIME: smoothing_time = cfg_data;
                    default: ;
                endcase
            end
            if (evt_valid && !evt_stall)
                advance_meter(timestamp_us);
        end
    end

    always @(posedge clk)
    begin
        fps_reading_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: reading with none expected, rate_q8 %0d measured %0d refresh %0d",
                             $time, rate_q8, measured, refresh);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (rate_q8 !== want.rate_q8)
                    begin
                        $display("%0t: rate_q8 expected %0d actual %0d",
                                 $time, want.rate_q8, rate_q8);
                        mismatches++;
                    end
                    if (measured !== want.measured)
                    begin
                        $display("%0t: measured expected %0d actual %0d",
                                 $time, want.measured, measured);
                        mismatches++;
                    end
                    if (refresh !== want.refresh)
                    begin
                        $display("%0t: refresh expected %0d actual %0d",
                                 $time, want.refresh, refresh);
                        mismatches++;
                    end
                end
            end
            res_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("%0t: no request completed for %0d cycles", $time, quiet_cycles);
                $display("[frame_rate_meter_ema] ERROR");
                $finish;
            end
        end
    end

    task automatic send_event(input logic [31:0] stamp);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            evt_valid <= 1'b0;
            @(posedge clk);
        end
        evt_valid <= 1'b1;
        timestamp_us <= stamp;
        do
            @(posedge clk);
        while (evt_stall);
    endtask

    task automatic wait_until_drained();
        evt_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_readings.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [25:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic configure(input logic [25:0] period, input logic [25:0] smoothing);
        wait_until_drained();
        write_register(CFG_REFRESH_PERIOD, period);
        write_register(CFG_SMOOTHING_TIME, smoothing);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [25:0] random_register();
        int unsigned pick;
        pick = $urandom_range(2);
        if (pick == 0)
            return 26'($urandom_range(2000, 1));
        else if (pick == 1)
            return 26'($urandom_range(200000, 1));
        return 26'($urandom_range(60000000, 1));
    endfunction

    function automatic logic [31:0] next_stamp();
        int unsigned pick;
        logic [31:0] dt;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            stamp_clock = $urandom();
            return stamp_clock;
        end
        if (pick < 20)
            dt = 32'd0;
        else if (pick < 35)
            dt = $urandom_range(20, 1);
        else if (pick < 50)
            dt = $urandom_range(1000, 21);
        else if (pick < 90)
            dt = $urandom_range(100000, 1001);
        else
            dt = $urandom_range(32'hFFFF_FFFF, 1000000);
        stamp_clock = stamp_clock + dt;
        return stamp_clock;
    endfunction

    task automatic run_frames(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_event(next_stamp());
            if ($urandom_range(49) == 0)
                wait_until_drained();
        end
    endtask

    // The first frames cover the first event, repeated stamps, a long interval while the
    // smoothed rate is still zero, saturation of short intervals, wrap and accumulator overflow.
    task automatic test_directed_intervals();
        logic [31:0] steps [17];
        steps = '{32'd0, 32'h9000_0000, 32'd0, 32'd16667, 32'd16667, 32'd1, 32'd15, 32'd16,
                  32'd17, 32'd100, 32'hFFFF_FFFF, 32'd256000000, 32'd256000001, 32'd33333,
                  32'd33333, 32'd1000000, 32'd250000};
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        stamp_clock = 32'hFFFF_FF00;
        send_event(stamp_clock);
        foreach (steps[i])
        begin
            stamp_clock = stamp_clock + steps[i];
            send_event(stamp_clock);
        end
    endtask

    task automatic test_register_extremes();
        sender_idle_pct = 16;
        receiver_stall_pct = 16;
        configure(26'd1, 26'd1);
        run_frames(40);
        configure(26'd0, 26'd0);
        run_frames(40);
        configure(CFG_RANGE_TOP, CFG_RANGE_TOP);
        run_frames(40);
        configure(CFG_ALL_ONES, CFG_ALL_ONES);
        run_frames(40);
        wait_until_drained();
        write_register(CFG_SPARE_LOW, CFG_ALL_ONES);
        write_register(CFG_SPARE_HIGH, 26'd0);
        cfg_valid <= 1'b0;
        @(posedge clk);
        run_frames(40);
        configure(26'd500000, 26'd1000000);
        run_frames(40);
    endtask

    task automatic test_random_traffic();
        int idle_plan [4][2];
        idle_plan = '{'{0, 0}, '{65, 0}, '{0, 65}, '{16, 16}};
        foreach (idle_plan[p])
        begin
            sender_idle_pct = idle_plan[p][0];
            receiver_stall_pct = idle_plan[p][1];
            configure(random_register(), random_register());
            run_frames(150);
            configure(random_register(), random_register());
            run_frames(150);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_intervals();
        test_register_extremes();
        test_random_traffic();
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("[frame_rate_meter_ema] OK");
        else
            $display("[frame_rate_meter_ema] ERROR");
        $finish;
    end

endmodule
